// ----- rtl/bvhq_pkg.sv -----
// Package with the types and constants of the box query engine.
`timescale 1ns / 1ps
package bvhq_pkg;

    localparam int MAX_RESULTS = 64;
    localparam int CNT_W       = 7;

    typedef enum logic [1:0] {
        ACT_NODE  = 2'd0,
        ACT_SEG   = 2'd1,
        ACT_QUERY = 2'd2,
        ACT_CLEAR = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        PH_TEST  = 2'd0,
        PH_LEFT  = 2'd1,
        PH_RIGHT = 2'd2,
        PH_DONE  = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_EXEC,
        ST_SEG,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic signed [31:0] min_x;
        logic signed [31:0] min_y;
        logic signed [31:0] max_x;
        logic signed [31:0] max_y;
        logic        [7:0]  left;
        logic        [6:0]  right;
    } node_t;

    typedef struct packed {
        logic signed [31:0] start_x;
        logic signed [31:0] start_y;
        logic signed [31:0] end_x;
        logic signed [31:0] end_y;
    } seg_t;

endpackage

// ----- rtl/bvhq_if.sv -----
// Channel interfaces for command words and result words.
`timescale 1ns / 1ps
interface bvhq_cmd_if;
    logic               valid;
    logic               ready;
    logic [1:0]         action;
    logic [6:0]         index;
    logic signed [7:0]  left_child;
    logic [6:0]         right_child;
    logic signed [31:0] coord_a_x;
    logic signed [31:0] coord_a_y;
    logic signed [31:0] coord_b_x;
    logic signed [31:0] coord_b_y;

    modport source (output valid, action, index, left_child, right_child,
                    coord_a_x, coord_a_y, coord_b_x, coord_b_y, input ready);
    modport sink (input valid, action, index, left_child, right_child,
                  coord_a_x, coord_a_y, coord_b_x, coord_b_y, output ready);
endinterface

interface bvhq_res_if;
    logic               valid;
    logic               ready;
    logic               hit;
    logic [5:0]         segment_index;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
    logic               last;

    modport source (output valid, hit, segment_index, start_x, start_y, end_x, end_y,
                    last, input ready);
    modport sink (input valid, hit, segment_index, start_x, start_y, end_x, end_y,
                  last, output ready);
endinterface

// ----- rtl/bvhq_mem.sv -----
// Node and segment memories with registered reads.
`timescale 1ns / 1ps
module bvhq_mem #(
    parameter int NODES    = 128,
    parameter int SEGMENTS = 64,
    parameter int NW       = 7,
    parameter int SW       = 6
) (
    input  logic            clk,
    input  logic            node_we,
    input  logic [NW-1:0]   node_waddr,
    input  bvhq_pkg::node_t node_wdata,
    input  logic            node_re,
    input  logic [NW-1:0]   node_raddr,
    output bvhq_pkg::node_t node_rdata,
    input  logic            seg_we,
    input  logic [SW-1:0]   seg_waddr,
    input  bvhq_pkg::seg_t  seg_wdata,
    input  logic            seg_re,
    input  logic [SW-1:0]   seg_raddr,
    output bvhq_pkg::seg_t  seg_rdata
);

    bvhq_pkg::node_t node_mem [NODES];
    bvhq_pkg::seg_t  seg_mem [SEGMENTS];

    always_ff @(posedge clk)
    begin
        if (node_we)
        begin
            node_mem[node_waddr] <= node_wdata;
        end
        if (node_re)
        begin
            node_rdata <= node_mem[node_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (seg_we)
        begin
            seg_mem[seg_waddr] <= seg_wdata;
        end
        if (seg_re)
        begin
            seg_rdata <= seg_mem[seg_raddr];
        end
    end

endmodule

// ----- rtl/bvh_box_query_engine_core.sv -----
// Box query engine: walks a bounding-volume tree held in memory, one node at a time.
// Node writes, segment writes and tree clears are taken only in the idle state.
// A query is accepted while idle; a walk step reads a node (FETCH), then evaluates it
// (EXEC); a hit adds a segment read (SEG); FINISH flags the final word. Result-side
// stalls hold the walk. A hit word leaves once the next hit or the end is known.
// Reset clears the control state and the tree-present flag; memories are not cleared.
`timescale 1ns / 1ps
module bvh_box_query_engine_core #(
    parameter int NODES       = 128,
    parameter int SEGMENTS    = 64,
    parameter int STACK_DEPTH = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    bvhq_cmd_if.sink    cmd,
    bvhq_res_if.source  res
);

    localparam int NW = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int SW = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
    localparam int LW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    bvhq_pkg::state_t state_reg, state_next;
    logic [LW-1:0]    level_reg, level_next;
    logic             tree_reg, tree_next;
    logic [bvhq_pkg::CNT_W-1:0] count_reg, count_next;
    logic signed [31:0] q_min_x_reg, q_min_y_reg, q_max_x_reg, q_max_y_reg;
    logic             q_load;
    logic [5:0]       cur_seg_reg, cur_seg_next;
    logic             pend_valid_reg, pend_valid_next;
    logic [5:0]       pend_idx_reg;
    bvhq_pkg::seg_t   pend_reg;
    logic             pend_load;

    logic             out_valid_reg, out_valid_next;
    logic             out_hit_reg, out_last_reg;
    logic [5:0]       out_idx_reg;
    bvhq_pkg::seg_t   out_reg;
    logic             out_load, out_hit_in, out_last_in;
    logic             out_free;

    logic [NW-1:0]           stack_node_reg [STACK_DEPTH];
    bvhq_pkg::phase_t        stack_phase_reg [STACK_DEPTH];
    logic                    stk_a_we, stk_b_we;
    logic [LW-1:0]           stk_a_idx, stk_b_idx;
    logic [NW-1:0]           stk_a_node;
    bvhq_pkg::phase_t        stk_a_phase, stk_b_phase;

    logic             node_we, node_re, seg_we, seg_re;
    bvhq_pkg::node_t  node_wdata, node_rdata;
    bvhq_pkg::seg_t   seg_wdata, seg_rdata;
    logic [SW-1:0]    seg_raddr;

    logic             cmd_fire;
    logic             overlap;
    logic             can_push;
    logic [6:0]       child;

    assign cmd.ready = (state_reg == bvhq_pkg::ST_IDLE);
    assign cmd_fire  = cmd.valid && cmd.ready;
    assign out_free  = !out_valid_reg || res.ready;

    assign node_wdata = '{min_x: cmd.coord_a_x, min_y: cmd.coord_a_y,
                          max_x: cmd.coord_b_x, max_y: cmd.coord_b_y,
                          left: cmd.left_child, right: cmd.right_child};
    assign seg_wdata  = '{start_x: cmd.coord_a_x, start_y: cmd.coord_a_y,
                          end_x: cmd.coord_b_x, end_y: cmd.coord_b_y};

    // Strict overlap: boxes that only touch do not count.
    assign overlap = (q_min_x_reg < node_rdata.max_x) && (node_rdata.min_x < q_max_x_reg) &&
                     (q_min_y_reg < node_rdata.max_y) && (node_rdata.min_y < q_max_y_reg);

    assign can_push = (int'({1'b0, level_reg}) + 1) < STACK_DEPTH;

    bvhq_mem #(
        .NODES    (NODES),
        .SEGMENTS (SEGMENTS),
        .NW       (NW),
        .SW       (SW)
    ) u_mem (
        .clk        (clk),
        .node_we    (node_we),
        .node_waddr (NW'(cmd.index)),
        .node_wdata (node_wdata),
        .node_re    (node_re),
        .node_raddr (stack_node_reg[level_reg]),
        .node_rdata (node_rdata),
        .seg_we     (seg_we),
        .seg_waddr  (SW'(cmd.index)),
        .seg_wdata  (seg_wdata),
        .seg_re     (seg_re),
        .seg_raddr  (seg_raddr),
        .seg_rdata  (seg_rdata)
    );

    always_comb
    begin
        state_next      = state_reg;
        level_next      = level_reg;
        tree_next       = tree_reg;
        count_next      = count_reg;
        cur_seg_next    = cur_seg_reg;
        pend_valid_next = pend_valid_reg;
        pend_load       = 1'b0;
        q_load          = 1'b0;
        out_load        = 1'b0;
        out_hit_in      = 1'b0;
        out_last_in     = 1'b0;
        stk_a_we        = 1'b0;
        stk_a_idx       = '0;
        stk_a_node      = '0;
        stk_a_phase     = bvhq_pkg::PH_TEST;
        stk_b_we        = 1'b0;
        stk_b_idx       = level_reg;
        stk_b_phase     = bvhq_pkg::PH_DONE;
        node_we         = 1'b0;
        node_re         = 1'b0;
        seg_we          = 1'b0;
        seg_re          = 1'b0;
        seg_raddr       = SW'(node_rdata.right);
        child           = '0;

        case (state_reg)
            bvhq_pkg::ST_IDLE:
            begin
                if (cmd_fire)
                begin
                    case (bvhq_pkg::action_t'(cmd.action))
                        bvhq_pkg::ACT_NODE:
                        begin
                            if (32'(cmd.index) < NODES)
                            begin
                                node_we   = 1'b1;
                                tree_next = 1'b1;
                            end
                        end
                        bvhq_pkg::ACT_SEG:
                        begin
                            seg_we = (32'(cmd.index) < SEGMENTS);
                        end
                        bvhq_pkg::ACT_QUERY:
                        begin
                            q_load          = 1'b1;
                            count_next      = '0;
                            pend_valid_next = 1'b0;
                            level_next      = '0;
                            if (tree_reg)
                            begin
                                stk_a_we   = 1'b1;
                                state_next = bvhq_pkg::ST_FETCH;
                            end
                            else
                            begin
                                state_next = bvhq_pkg::ST_FINISH;
                            end
                        end
                        default:
                        begin
                            tree_next = 1'b0;
                        end
                    endcase
                end
            end
            bvhq_pkg::ST_FETCH:
            begin
                node_re    = 1'b1;
                state_next = bvhq_pkg::ST_EXEC;
            end
            bvhq_pkg::ST_EXEC:
            begin
                stk_b_we   = 1'b1;
                state_next = bvhq_pkg::ST_FETCH;
                case (stack_phase_reg[level_reg])
                    bvhq_pkg::PH_TEST:
                    begin
                        if (!overlap)
                        begin
                            stk_b_phase = bvhq_pkg::PH_DONE;
                        end
                        else if (node_rdata.left[7])
                        begin
                            stk_b_phase = bvhq_pkg::PH_DONE;
                            if (32'(node_rdata.right) < SEGMENTS)
                            begin
                                seg_re       = 1'b1;
                                cur_seg_next = node_rdata.right[5:0];
                                state_next   = bvhq_pkg::ST_SEG;
                            end
                        end
                        else
                        begin
                            stk_b_phase = bvhq_pkg::PH_LEFT;
                        end
                    end
                    bvhq_pkg::PH_LEFT,
                    bvhq_pkg::PH_RIGHT:
                    begin
                        if (stack_phase_reg[level_reg] == bvhq_pkg::PH_LEFT)
                        begin
                            stk_b_phase = bvhq_pkg::PH_RIGHT;
                            child       = node_rdata.left[6:0];
                        end
                        else
                        begin
                            stk_b_phase = bvhq_pkg::PH_DONE;
                            child       = node_rdata.right;
                        end
                        if ((32'(child) < NODES) && can_push)
                        begin
                            level_next = level_reg + 1'b1;
                            stk_a_we   = 1'b1;
                            stk_a_idx  = level_reg + 1'b1;
                            stk_a_node = NW'(child);
                        end
                    end
                    default:
                    begin
                        stk_b_we = 1'b0;
                        if (level_reg == '0)
                        begin
                            state_next = bvhq_pkg::ST_FINISH;
                        end
                        else
                        begin
                            level_next = level_reg - 1'b1;
                        end
                    end
                endcase
            end
            bvhq_pkg::ST_SEG:
            begin
                // The held hit goes out as a non-final word before the new one takes its place.
                if (!pend_valid_reg || out_free)
                begin
                    out_load        = pend_valid_reg;
                    out_hit_in      = 1'b1;
                    pend_load       = 1'b1;
                    pend_valid_next = 1'b1;
                    count_next      = count_reg + 1'b1;
                    if (count_next == bvhq_pkg::CNT_W'(bvhq_pkg::MAX_RESULTS))
                    begin
                        state_next = bvhq_pkg::ST_FINISH;
                    end
                    else
                    begin
                        state_next = bvhq_pkg::ST_FETCH;
                    end
                end
            end
            bvhq_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    out_load        = 1'b1;
                    out_hit_in      = pend_valid_reg;
                    out_last_in     = 1'b1;
                    pend_valid_next = 1'b0;
                    level_next      = '0;
                    state_next      = bvhq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bvhq_pkg::ST_IDLE;
            end
        endcase

        out_valid_next = out_load ? 1'b1 : (res.ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= bvhq_pkg::ST_IDLE;
            level_reg      <= '0;
            tree_reg       <= 1'b0;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            level_reg      <= level_next;
            tree_reg       <= tree_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_seg_reg <= cur_seg_next;
        if (q_load)
        begin
            q_min_x_reg <= cmd.coord_a_x;
            q_min_y_reg <= cmd.coord_a_y;
            q_max_x_reg <= cmd.coord_b_x;
            q_max_y_reg <= cmd.coord_b_y;
        end
        if (pend_load)
        begin
            pend_reg     <= seg_rdata;
            pend_idx_reg <= cur_seg_reg;
        end
        if (out_load)
        begin
            out_hit_reg  <= out_hit_in;
            out_last_reg <= out_last_in;
            out_idx_reg  <= out_hit_in ? pend_idx_reg : 6'd0;
            out_reg      <= out_hit_in ? pend_reg : '0;
        end
        if (stk_b_we)
        begin
            stack_phase_reg[stk_b_idx] <= stk_b_phase;
        end
        if (stk_a_we)
        begin
            stack_node_reg[stk_a_idx]  <= stk_a_node;
            stack_phase_reg[stk_a_idx] <= stk_a_phase;
        end
    end

    assign res.valid         = out_valid_reg;
    assign res.hit           = out_hit_reg;
    assign res.segment_index = out_idx_reg;
    assign res.start_x       = out_reg.start_x;
    assign res.start_y       = out_reg.start_y;
    assign res.end_x         = out_reg.end_x;
    assign res.end_y         = out_reg.end_y;
    assign res.last          = out_last_reg;

endmodule

// ----- tb/bvhq_checker.sv -----
// Checker for the box query engine: mirrors the tree, predicts query results and compares them.
`timescale 1ns / 1ps
module bvhq_checker #(
    parameter int NODES       = 128,
    parameter int SEGMENTS    = 64,
    parameter int STACK_DEPTH = 8
) (
    input  logic clk,
    input  logic rst_n,
    bvhq_cmd_if  cmd,
    bvhq_res_if  res,
    output int   errors,
    output int   pending
);

    typedef struct {
        logic               hit;
        logic [5:0]         segment_index;
        logic signed [31:0] start_x;
        logic signed [31:0] start_y;
        logic signed [31:0] end_x;
        logic signed [31:0] end_y;
        logic               last;
    } hit_word_t;

    logic signed [31:0] box_min_x [NODES];
    logic signed [31:0] box_min_y [NODES];
    logic signed [31:0] box_max_x [NODES];
    logic signed [31:0] box_max_y [NODES];
    logic [7:0]         child_l [NODES];
    logic [6:0]         child_r [NODES];
    bvhq_pkg::seg_t     segs [SEGMENTS];
    logic               tree_loaded;
    hit_word_t          hits_due [$];
    int                 err_count = 0;
    int                 due_count = 0;

    assign errors  = err_count;
    assign pending = due_count;

    function automatic logic box_overlaps(int n, logic signed [31:0] qx0,
                                          logic signed [31:0] qy0,
                                          logic signed [31:0] qx1,
                                          logic signed [31:0] qy1);
        return (qx0 < box_max_x[n]) && (box_min_x[n] < qx1) &&
               (qy0 < box_max_y[n]) && (box_min_y[n] < qy1);
    endfunction

    // Depth-first walk of the mirrored tree, left child first, with a bounded stack.
    task automatic walk_query(logic signed [31:0] qx0, logic signed [31:0] qy0,
                              logic signed [31:0] qx1, logic signed [31:0] qy1);
        int                lv;
        int                n;
        int                child;
        int                s;
        int                walk_node [STACK_DEPTH];
        bvhq_pkg::phase_t  walk_phase [STACK_DEPTH];
        hit_word_t         found [$];
        hit_word_t         w;
        lv = 0;
        walk_node[0] = 0;
        walk_phase[0] = bvhq_pkg::PH_TEST;
        while (tree_loaded && found.size() < bvhq_pkg::MAX_RESULTS)
        begin
            n = walk_node[lv];
            child = -1;
            case (walk_phase[lv])
                bvhq_pkg::PH_TEST:
                begin
                    if (!box_overlaps(n, qx0, qy0, qx1, qy1))
                    begin
                        walk_phase[lv] = bvhq_pkg::PH_DONE;
                    end
                    else if (child_l[n][7])
                    begin
                        s = child_r[n];
                        if (s < SEGMENTS)
                        begin
                            w.hit = 1'b1;
                            w.segment_index = s[5:0];
                            w.start_x = segs[s].start_x;
                            w.start_y = segs[s].start_y;
                            w.end_x = segs[s].end_x;
                            w.end_y = segs[s].end_y;
                            w.last = 1'b0;
                            found.insert(found.size(), w);
                        end
                        walk_phase[lv] = bvhq_pkg::PH_DONE;
                    end
                    else
                    begin
                        walk_phase[lv] = bvhq_pkg::PH_LEFT;
                    end
                end
                bvhq_pkg::PH_LEFT:
                begin
                    walk_phase[lv] = bvhq_pkg::PH_RIGHT;
                    child = child_l[n][6:0];
                end
                bvhq_pkg::PH_RIGHT:
                begin
                    walk_phase[lv] = bvhq_pkg::PH_DONE;
                    child = child_r[n];
                end
                default:
                begin
                    if (lv == 0)
                        break;
                    lv--;
                end
            endcase
            // A child that would not fit on the stack is dropped.
            if (child >= 0 && child < NODES && lv + 1 < STACK_DEPTH)
            begin
                lv++;
                walk_node[lv] = child;
                walk_phase[lv] = bvhq_pkg::PH_TEST;
            end
        end
        if (found.size() == 0)
        begin
            w = '{hit: 1'b0, segment_index: '0, start_x: '0, start_y: '0,
                  end_x: '0, end_y: '0, last: 1'b1};
            found.insert(found.size(), w);
        end
        found[found.size() - 1].last = 1'b1;
        foreach (found[i])
            hits_due.insert(hits_due.size(), found[i]);
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            err_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        hit_word_t w;
        if (!rst_n)
        begin
            tree_loaded = 1'b0;
        end
        else
        begin
            if (cmd.valid && cmd.ready)
            begin
                case (bvhq_pkg::action_t'(cmd.action))
                    bvhq_pkg::ACT_NODE:
                    begin
                        box_min_x[cmd.index] = cmd.coord_a_x;
                        box_min_y[cmd.index] = cmd.coord_a_y;
                        box_max_x[cmd.index] = cmd.coord_b_x;
                        box_max_y[cmd.index] = cmd.coord_b_y;
                        child_l[cmd.index] = cmd.left_child;
                        child_r[cmd.index] = cmd.right_child;
                        tree_loaded = 1'b1;
                    end
                    bvhq_pkg::ACT_SEG:
                    begin
                        if (cmd.index < SEGMENTS)
                            segs[cmd.index] = '{cmd.coord_a_x, cmd.coord_a_y,
                                                cmd.coord_b_x, cmd.coord_b_y};
                    end
                    bvhq_pkg::ACT_QUERY:
                    begin
                        walk_query(cmd.coord_a_x, cmd.coord_a_y,
                                   cmd.coord_b_x, cmd.coord_b_y);
                    end
                    default:
                    begin
                        tree_loaded = 1'b0;
                    end
                endcase
            end
            if (res.valid && res.ready)
            begin
                if (hits_due.size() == 0)
                begin
                    $display("%0t: unexpected result word, expected none, actual hit %0b seg %0d",
                             $time, res.hit, res.segment_index);
                    err_count++;
                end
                else
                begin
                    w = hits_due.pop_front();
                    check_field("hit", 32'(w.hit), 32'(res.hit));
                    check_field("segment_index", 32'(w.segment_index),
                                32'(res.segment_index));
                    check_field("start_x", w.start_x, res.start_x);
                    check_field("start_y", w.start_y, res.start_y);
                    check_field("end_x", w.end_x, res.end_x);
                    check_field("end_y", w.end_y, res.end_y);
                    check_field("last", 32'(w.last), 32'(res.last));
                end
            end
            due_count = hits_due.size();
        end
    end
endmodule

// ----- tb/testbench.sv -----
// Top of the box query engine testbench: clock, reset, command stimulus and the verdict.
`timescale 1ns / 1ps
module testbench;

    localparam int NODES    = 128;
    localparam int SEGMENTS = 64;
    localparam int SPAN     = 32'h0040_0000;

    typedef struct {
        bvhq_pkg::action_t  act;
        logic [6:0]         idx;
        logic signed [7:0]  lc;
        logic [6:0]         rc;
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic signed [31:0] bx;
        logic signed [31:0] by;
    } cmd_word_t;

    logic clk;
    logic rst_n;
    int   errors;
    int   pending;
    int   words_sent;
    logic calm;
    int   stall_left;

    bvhq_cmd_if cmd_ch ();
    bvhq_res_if res_ch ();

    bvh_box_query_engine_core uut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .res   (res_ch)
    );

    bvhq_checker chk (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd_ch),
        .res     (res_ch),
        .errors  (errors),
        .pending (pending)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // The result side stalls in random bursts, mostly short.
    always @(negedge clk)
    begin
        if (!rst_n || calm)
        begin
            res_ch.ready <= rst_n;
            stall_left <= 0;
        end
        else if (stall_left > 0)
        begin
            res_ch.ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            res_ch.ready <= 1'b1;
            stall_left <= pick_gap();
        end
    end

    task automatic send(cmd_word_t w);
        int gap;
        @(negedge clk);
        cmd_ch.valid <= 1'b1;
        cmd_ch.action <= w.act;
        cmd_ch.index <= w.idx;
        cmd_ch.left_child <= w.lc;
        cmd_ch.right_child <= w.rc;
        cmd_ch.coord_a_x <= w.ax;
        cmd_ch.coord_a_y <= w.ay;
        cmd_ch.coord_b_x <= w.bx;
        cmd_ch.coord_b_y <= w.by;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        words_sent++;
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            cmd_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic put_node(int idx, logic signed [7:0] lc, int rc,
                            logic signed [31:0] x0, logic signed [31:0] y0,
                            logic signed [31:0] x1, logic signed [31:0] y1);
        send('{bvhq_pkg::ACT_NODE, idx[6:0], lc, rc[6:0], x0, y0, x1, y1});
    endtask

    task automatic put_seg(int idx, logic signed [31:0] x0, logic signed [31:0] y0,
                           logic signed [31:0] x1, logic signed [31:0] y1);
        send('{bvhq_pkg::ACT_SEG, idx[6:0], 8'sd0, 7'd0, x0, y0, x1, y1});
    endtask

    task automatic ask(logic signed [31:0] x0, logic signed [31:0] y0,
                       logic signed [31:0] x1, logic signed [31:0] y1);
        send('{bvhq_pkg::ACT_QUERY, 7'($urandom), 8'($urandom), 7'($urandom),
               x0, y0, x1, y1});
    endtask

    task automatic wipe();
        send('{bvhq_pkg::ACT_CLEAR, 7'($urandom), 8'($urandom), 7'($urandom),
               $urandom, $urandom, $urandom, $urandom});
    endtask

    function automatic logic signed [31:0] near_coord();
        return $signed($urandom_range(0, 2 * SPAN)) - SPAN;
    endfunction

    function automatic logic signed [7:0] leaf_mark();
        return $urandom_range(0, 1) ? -8'sd1 : -$signed(8'($urandom_range(1, 128)));
    endfunction

    // Loads a full binary tree in heap order with boxes that enclose their children,
    // then asks a few queries over the same area.
    task automatic load_tree_and_ask();
        int leaves;
        int total;
        int seg;
        logic signed [31:0] t;
        logic signed [31:0] x0 [16];
        logic signed [31:0] y0 [16];
        logic signed [31:0] x1 [16];
        logic signed [31:0] y1 [16];
        leaves = $urandom_range(1, 8);
        total = 2 * leaves - 1;
        for (int i = total - 1; i >= 0; i--)
        begin
            if (i >= leaves - 1)
            begin
                x0[i] = near_coord();
                y0[i] = near_coord();
                x1[i] = near_coord();
                y1[i] = near_coord();
                if (x0[i] > x1[i])
                begin
                    t = x0[i];
                    x0[i] = x1[i];
                    x1[i] = t;
                end
                if (y0[i] > y1[i])
                begin
                    t = y0[i];
                    y0[i] = y1[i];
                    y1[i] = t;
                end
                seg = ($urandom_range(0, 9) == 0) ? $urandom_range(SEGMENTS, 127)
                                                  : $urandom_range(0, SEGMENTS - 1);
                if (seg < SEGMENTS)
                    put_seg(seg, x0[i], y0[i], x1[i], y1[i]);
                put_node(i, leaf_mark(), seg, x0[i], y0[i], x1[i], y1[i]);
            end
            else
            begin
                x0[i] = (x0[2*i+1] < x0[2*i+2]) ? x0[2*i+1] : x0[2*i+2];
                y0[i] = (y0[2*i+1] < y0[2*i+2]) ? y0[2*i+1] : y0[2*i+2];
                x1[i] = (x1[2*i+1] > x1[2*i+2]) ? x1[2*i+1] : x1[2*i+2];
                y1[i] = (y1[2*i+1] > y1[2*i+2]) ? y1[2*i+1] : y1[2*i+2];
                put_node(i, 8'(2 * i + 1), 2 * i + 2, x0[i], y0[i], x1[i], y1[i]);
            end
        end
        repeat ($urandom_range(3, 6))
        begin
            x0[15] = near_coord();
            y0[15] = near_coord();
            ask(x0[15], y0[15], x0[15] + $urandom_range(0, SPAN),
                y0[15] + $urandom_range(0, SPAN));
        end
    endtask

    localparam logic signed [31:0] LO = 32'sh8000_0000;
    localparam logic signed [31:0] HI = 32'sh7FFF_FFFF;

    initial
    begin
        int r;
        calm = 1'b1;
        words_sent = 0;
        cmd_ch.valid = 1'b0;
        cmd_ch.action = bvhq_pkg::ACT_NODE;
        cmd_ch.index = '0;
        cmd_ch.left_child = '0;
        cmd_ch.right_child = '0;
        cmd_ch.coord_a_x = '0;
        cmd_ch.coord_a_y = '0;
        cmd_ch.coord_b_x = '0;
        cmd_ch.coord_b_y = '0;
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Query with no tree loaded.
        ask(LO, LO, HI, HI);
        wipe();

        // Fill every node and segment so that no walk reads an unwritten entry.
        for (int s = 0; s < SEGMENTS; s++)
            put_seg(s, $urandom, $urandom, $urandom, $urandom);
        for (int n = 0; n < NODES; n++)
            put_node(n, -8'sd1, $urandom_range(0, 127), near_coord(), near_coord(),
                     near_coord(), near_coord());

        calm = 1'b0;
        // Extremes: a full-range root, one leaf at the last segment, one naming no segment.
        put_seg(63, LO, HI, HI, LO);
        put_seg(127, HI, HI, HI, HI);
        put_node(0, 8'sd1, 2, LO, LO, HI, HI);
        put_node(1, -8'sd128, 63, 32'sh0001_0000, 32'sh0001_0000,
                 32'sh0002_0000, 32'sh0002_0000);
        put_node(2, -8'sd1, 100, LO, LO, HI, HI);
        ask(LO, LO, HI, HI);
        // Boxes that only touch at an edge do not count.
        ask(32'sh0002_0000, 32'sh0001_0000, 32'sh0003_0000, 32'sh0002_0000);
        ask(32'sh0001_8000, 32'sh0001_8000, 32'sh0001_8001, 32'sh0001_8001);
        // Every branch doubles: more than 64 leaves are reached and the stack fills.
        for (int n = 0; n < 7; n++)
            put_node(n, 8'(n + 1), n + 1, LO, LO, HI, HI);
        put_node(7, -8'sd1, 5, LO, LO, HI, HI);
        ask(LO, LO, HI, HI);
        // A chain deeper than the stack.
        for (int n = 0; n < 10; n++)
            put_node(n, 8'sd127, n + 1, LO, LO, HI, HI);
        put_node(127, -8'sd1, 9, LO, LO, HI, HI);
        ask(32'sh0, 32'sh0, 32'sh1, 32'sh1);
        wipe();
        ask(LO, LO, HI, HI);

        while (words_sent < 450)
        begin
            r = $urandom_range(0, 99);
            if (r < 50)
            begin
                calm = ($urandom_range(0, 4) == 0);
                load_tree_and_ask();
            end
            else if (r < 70)
                put_node($urandom_range(0, 127), 8'($urandom), $urandom_range(0, 127),
                         $urandom, $urandom, $urandom, $urandom);
            else if (r < 82)
                put_seg($urandom_range(0, 127), $urandom, $urandom, $urandom, $urandom);
            else if (r < 88)
                wipe();
            else
                ask($urandom, $urandom, $urandom, $urandom);
        end

        @(negedge clk);
        cmd_ch.valid <= 1'b0;
        calm = 1'b0;
        wait (pending == 0);
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #200_000_000;
        $display("CHECKS FAILED");
        $finish;
    end
endmodule
